[rtl/sjfq_pkg.sv]
`default_nettype none

package sjfq_pkg;

    // task slots follow from the width of the task index
    localparam int TASK_W     = 4;
    localparam int NUM_SLOTS  = 1 << TASK_W;
    localparam int Q_W        = 24;
    localparam int FRAC_W     = 8;
    localparam int BURST_W    = 16;
    localparam int ALPHA_W    = 9;
    localparam int ACC_W      = 32;
    localparam int CNT_OUT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // command codes
    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_BURST   = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SJF_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q8      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ESTIMATE = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [TASK_W-1:0]  task_index;
        logic [BURST_W-1:0] burst_length;
    } sjfq_cmd_t;

    typedef struct packed {
        logic [TASK_W-1:0]    head_index;
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] queue_count;
    } sjfq_rsp_t;

    typedef struct packed {
        logic en;
        logic clear;
    } sjfq_mac_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DEQ_RD,
        ST_DEQ_LOAD,
        ST_EST_RD,
        ST_EST_MUL_OLD,
        ST_EST_MUL_BURST,
        ST_EST_WR,
        ST_SCAN_RD,
        ST_SCAN_EST,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } sjfq_state_t;

endpackage

`default_nettype wire

[rtl/sjfq_mac.sv]
`default_nettype none

module sjfq_mac
    import sjfq_pkg::*;
(
    input  wire logic              clk,
    input  wire sjfq_mac_ctl_t     ctl,
    input  wire logic [Q_W-1:0]    opa,
    input  wire logic [ALPHA_W-1:0] opb,
    output logic      [ACC_W-1:0]  acc
);

    logic [Q_W+ALPHA_W-1:0] prod;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       acc_next;

    // one weighted term per cycle while enabled, summed into the accumulator or starting a new sum on clear
    always_comb
    begin
        prod     = (Q_W+ALPHA_W)'(opa) * (Q_W+ALPHA_W)'(opb);
        acc_next = (ctl.clear ? '0 : acc_reg) + prod[ACC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[rtl/sjfq_table.sv]
`default_nettype none

module sjfq_table
    import sjfq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic [Q_W-1:0]    fill,
    input  wire logic              re,
    input  wire logic [TASK_W-1:0] raddr,
    input  wire logic              we,
    input  wire logic [TASK_W-1:0] waddr,
    input  wire logic [Q_W-1:0]    wdata,
    output logic      [Q_W-1:0]    rdata
);

    logic [Q_W-1:0]       mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] vld_reg;
    logic [NUM_SLOTS-1:0] vld_next;
    logic [Q_W-1:0]       rd_data_reg;
    logic                 rd_vld_reg;

    // an entry not written since the last clear or reset reads as the fill value
    always_comb
    begin
        vld_next = vld_reg;
        if (clear)
        begin
            vld_next = '0;
        end
        else if (we)
        begin
            vld_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (re)
            begin
                rd_vld_reg <= vld_reg[raddr];
            end
        end
    end

    // storage, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rd_data_reg : fill;

endmodule

`default_nettype wire

[rtl/sjfq_ram.sv]
`default_nettype none

module sjfq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 4
) (
    input  wire logic          clk,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

[rtl/sjf_ready_queue_unit.sv]
// Each item runs to its result before the next is taken. An ordered enqueue scans the
// queue from the head through the order memory, comparing each queued estimate with the new
// one until a larger queued estimate ends the scan, then moves later entries back one slot.
// A new item is taken only once the previous result is registered and the unit is idle.
// Reset: queue empty, registers to FIFO mode, alpha 128, base 0; tables read as base.
`default_nettype none

module sjf_ready_queue_unit
    import sjfq_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire sjfq_cmd_t             cmd,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output sjfq_rsp_t                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QIW = $clog2(MAX_TASKS);
    localparam int LW  = $clog2(MAX_TASKS + 1);

    // queue position to physical slot of the circular order memory
    function automatic logic [QIW-1:0] phys(input logic [QIW-1:0] base,
                                            input logic [LW-1:0]  off);
        logic [LW:0] sum;
        sum = (LW+1)'(base) + (LW+1)'(off);
        if (sum >= (LW+1)'(MAX_TASKS))
        begin
            sum = sum - (LW+1)'(MAX_TASKS);
        end
        return sum[QIW-1:0];
    endfunction

    sjfq_state_t         state_reg, state_next;
    sjfq_cmd_t           item_reg, item_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [QIW-1:0]      hd_reg, hd_next;
    logic [TASK_W-1:0]   head_reg, head_next;
    logic [TASK_W-1:0]   taken_reg, taken_next;
    logic                deq_ok_reg, deq_ok_next;
    logic [1:0]          status_reg, status_next;
    logic [LW-1:0]       pos_reg, pos_next;
    logic [LW-1:0]       idx_reg, idx_next;
    logic [Q_W-1:0]      new_est_reg, new_est_next;
    sjfq_rsp_t           rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                sjf_mode_reg;
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [BURST_W-1:0]  base_reg;

    logic [TASK_W-1:0]   t;
    logic                t_ok;
    logic                q_empty;
    logic                q_full;
    logic                rsp_load;
    logic                tbl_clear;
    logic [Q_W-1:0]      fill;
    logic [ALPHA_W-1:0]  alpha_sat;
    logic [Q_W-1:0]      est_calc;
    logic [QIW-1:0]      addr_pos;
    logic [QIW-1:0]      addr_idx;
    logic [QIW-1:0]      addr_idx_m1;
    logic [QIW-1:0]      addr_adv;

    logic                est_re, est_we;
    logic [TASK_W-1:0]   est_raddr;
    logic [Q_W-1:0]      est_rdata;
    logic                bur_re, bur_we;
    logic [TASK_W-1:0]   bur_waddr;
    logic [Q_W-1:0]      bur_wdata;
    logic [Q_W-1:0]      bur_rdata;
    logic                ord_re, ord_we;
    logic [QIW-1:0]      ord_raddr, ord_waddr;
    logic [TASK_W-1:0]   ord_wdata;
    logic [TASK_W-1:0]   ord_rdata;
    sjfq_mac_ctl_t       mac_ctl;
    logic [Q_W-1:0]      mac_opa;
    logic [ALPHA_W-1:0]  mac_opb;
    logic [ACC_W-1:0]    mac_acc;

    // common conditions
    assign t           = item_reg.task_index;
    assign t_ok        = 32'(t) < MAX_TASKS;
    assign q_empty     = len_reg == '0;
    assign q_full      = len_reg == LW'(MAX_TASKS);
    assign fill        = {base_reg, {FRAC_W{1'b0}}};
    assign alpha_sat   = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign est_calc    = mac_acc[ACC_W-1:ACC_W-Q_W];
    assign addr_pos    = phys(hd_reg, pos_reg);
    assign addr_idx    = phys(hd_reg, idx_reg);
    assign addr_idx_m1 = phys(hd_reg, idx_reg - 1'b1);
    assign addr_adv    = phys(hd_reg, LW'(1));
    assign rsp_load    = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready);
    assign tbl_clear   = cfg_we && (cfg_index == CFG_BASE_ESTIMATE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sjf_mode_reg <= 1'b0;
            alpha_reg    <= 9'd128;
            base_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SJF_MODE:      sjf_mode_reg <= cfg_data[0];
                CFG_ALPHA_Q8:      alpha_reg    <= cfg_data[ALPHA_W-1:0];
                CFG_BASE_ESTIMATE: base_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FINISH;
                case (item_reg.command)
                    CMD_ENQUEUE:
                    begin
                        if (t_ok && !q_full)
                        begin
                            state_next = sjf_mode_reg ? ST_EST_RD : ST_SHIFT_RD;
                        end
                    end
                    CMD_DEQUEUE:
                    begin
                        if (len_reg > LW'(1))
                        begin
                            state_next = ST_DEQ_RD;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DEQ_RD:        state_next = ST_DEQ_LOAD;
            ST_DEQ_LOAD:      state_next = ST_FINISH;
            ST_EST_RD:        state_next = ST_EST_MUL_OLD;
            ST_EST_MUL_OLD:   state_next = ST_EST_MUL_BURST;
            ST_EST_MUL_BURST: state_next = ST_EST_WR;
            ST_EST_WR:        state_next = ST_SCAN_RD;
            ST_SCAN_RD:
            begin
                state_next = (pos_reg == len_reg) ? ST_SHIFT_RD : ST_SCAN_EST;
            end
            ST_SCAN_EST:      state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
            begin
                state_next = (new_est_reg < est_rdata) ? ST_SHIFT_RD : ST_SCAN_RD;
            end
            ST_SHIFT_RD:
            begin
                state_next = (idx_reg == pos_reg) ? ST_FINISH : ST_SHIFT_WR;
            end
            ST_SHIFT_WR:      state_next = ST_SHIFT_RD;
            ST_FINISH:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:          state_next = ST_IDLE;
        endcase
    end

    // memory and arithmetic unit controls
    always_comb
    begin
        cmd_ready = state_reg == ST_IDLE;
        est_re    = 1'b0;
        est_raddr = t;
        est_we    = 1'b0;
        bur_re    = 1'b0;
        bur_we    = 1'b0;
        bur_waddr = t;
        bur_wdata = {item_reg.burst_length, {FRAC_W{1'b0}}};
        ord_re    = 1'b0;
        ord_raddr = addr_pos;
        ord_we    = 1'b0;
        ord_waddr = addr_pos;
        ord_wdata = t;
        mac_ctl   = '{en: 1'b0, clear: 1'b0};
        mac_opa   = est_rdata;
        mac_opb   = alpha_sat;
        case (state_reg)
            ST_DECODE:
            begin
                if (item_reg.command == CMD_BURST && t_ok)
                begin
                    bur_we = 1'b1;
                end
                else if (item_reg.command == CMD_DEQUEUE && !q_empty && sjf_mode_reg)
                begin
                    bur_we    = 1'b1;
                    bur_waddr = head_reg;
                    bur_wdata = '0;
                end
            end
            ST_DEQ_RD:
            begin
                ord_re    = 1'b1;
                ord_raddr = hd_reg;
            end
            ST_EST_RD:
            begin
                est_re = 1'b1;
                bur_re = 1'b1;
            end
            ST_EST_MUL_OLD:
            begin
                mac_ctl = '{en: 1'b1, clear: 1'b1};
            end
            ST_EST_MUL_BURST:
            begin
                mac_ctl = '{en: 1'b1, clear: 1'b0};
                mac_opa = bur_rdata;
                mac_opb = ALPHA_ONE - alpha_sat;
            end
            ST_EST_WR:
            begin
                est_we = 1'b1;
            end
            ST_SCAN_RD:
            begin
                ord_re = pos_reg != len_reg;
            end
            ST_SCAN_EST:
            begin
                est_re    = 1'b1;
                est_raddr = ord_rdata;
            end
            ST_SHIFT_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    ord_we = 1'b1;
                end
                else
                begin
                    ord_re    = 1'b1;
                    ord_raddr = addr_idx_m1;
                end
            end
            ST_SHIFT_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = addr_idx;
                ord_wdata = ord_rdata;
            end
            default: ;
        endcase
    end

    // queue bookkeeping and result registers
    always_comb
    begin
        item_next      = item_reg;
        len_next       = len_reg;
        hd_next        = hd_reg;
        head_next      = head_reg;
        taken_next     = taken_reg;
        deq_ok_next    = deq_ok_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        new_est_next   = new_est_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next   = cmd;
                    status_next = STS_OK;
                    deq_ok_next = 1'b0;
                end
            end
            ST_DECODE:
            begin
                pos_next = len_reg;
                idx_next = len_reg;
                case (item_reg.command)
                    CMD_ENQUEUE:
                    begin
                        if (t_ok && q_full)
                        begin
                            status_next = STS_FULL;
                        end
                    end
                    CMD_DEQUEUE:
                    begin
                        if (q_empty)
                        begin
                            status_next = STS_EMPTY;
                        end
                        else
                        begin
                            taken_next  = head_reg;
                            deq_ok_next = 1'b1;
                            hd_next     = addr_adv;
                            len_next    = len_reg - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DEQ_LOAD:
            begin
                head_next = ord_rdata;
            end
            ST_EST_WR:
            begin
                new_est_next = est_calc;
                pos_next     = '0;
            end
            ST_SCAN_CMP:
            begin
                if (!(new_est_reg < est_rdata))
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_SHIFT_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    len_next = len_reg + 1'b1;
                    if (pos_reg == '0)
                    begin
                        head_next = t;
                    end
                end
            end
            ST_SHIFT_WR:
            begin
                idx_next = idx_reg - 1'b1;
            end
            ST_FINISH:
            begin
                if (rsp_load)
                begin
                    rsp_next.head_index  = deq_ok_reg ? taken_reg :
                                           (q_empty ? '0 : head_reg);
                    rsp_next.status      = status_reg;
                    rsp_next.queue_count = CNT_OUT_W'(len_reg);
                    rsp_valid_next       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            hd_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            hd_reg        <= hd_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        head_reg    <= head_next;
        taken_reg   <= taken_next;
        deq_ok_reg  <= deq_ok_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        new_est_reg <= new_est_next;
        rsp_reg     <= rsp_next;
    end

    // estimate table
    sjfq_table u_est_table (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (tbl_clear),
        .fill  (fill),
        .re    (est_re),
        .raddr (est_raddr),
        .we    (est_we),
        .waddr (t),
        .wdata (est_calc),
        .rdata (est_rdata)
    );

    // last burst table
    sjfq_table u_burst_table (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (tbl_clear),
        .fill  (fill),
        .re    (bur_re),
        .raddr (t),
        .we    (bur_we),
        .waddr (bur_waddr),
        .wdata (bur_wdata),
        .rdata (bur_rdata)
    );

    // circular queue of task indices
    sjfq_ram #(
        .DEPTH (MAX_TASKS),
        .AW    (QIW),
        .DW    (TASK_W)
    ) u_order_ram (
        .clk   (clk),
        .re    (ord_re),
        .raddr (ord_raddr),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .rdata (ord_rdata)
    );

    // shared multiply-accumulate for the estimate blend
    sjfq_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .opa (mac_opa),
        .opb (mac_opb),
        .acc (mac_acc)
    );

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

[rtl/sjfq_checker.sv]
`default_nettype none

module sjfq_checker
    import sjfq_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cmd_valid,
    input wire logic      cmd_ready,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire sjfq_rsp_t rsp
);

    // the unit is busy in the cycle after it takes an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted while previous item in progress");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // empty dequeue reports an empty queue and no head
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STS_EMPTY |->
            rsp.queue_count == '0 && rsp.head_index == '0)
        else $error("empty status with tasks queued");

    // full status only when every slot is taken
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STS_FULL |->
            rsp.queue_count == CNT_OUT_W'(MAX_TASKS))
        else $error("full status with free slots");

endmodule

bind sjf_ready_queue_unit sjfq_checker #(
    .MAX_TASKS (MAX_TASKS)
) u_sjfq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
